### rtl/core/tfmm_pkg.sv
package tfmm_pkg;

  localparam int QUEUE_DEPTH_DEF      = 16;
  localparam int MAX_ACCESS_BYTES_DEF = 8;
  localparam int MEMORY_BYTES_DEF     = 65536;

  localparam int ADDR_W  = 16;
  localparam int LEN_W   = 4;
  localparam int TAG_W   = 16;
  localparam int SRC_W   = 4;
  localparam int DATA_W  = 64;
  localparam int LAT_W   = 16;
  localparam int LINE_W  = 9;
  localparam int SPAN_W  = 10;
  localparam int NUM_W   = LAT_W + SPAN_W;
  localparam int TICK_W  = 32;
  localparam int CFG_W   = 16;
  localparam int RED_STEPS = 9;
  localparam int RED_CNT_W = 4;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  localparam logic [1:0] CFG_BASE     = 2'd0;
  localparam logic [1:0] CFG_PER_LINE = 2'd1;
  localparam logic [1:0] CFG_LINE     = 2'd2;

  typedef enum logic [2:0] {
    KIND_ACCEPTED   = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_SIZE_ERR   = 3'd2,
    KIND_READ_DONE  = 3'd3,
    KIND_WRITE_DONE = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_DIV_START,
    S_DIV,
    S_REDUCE,
    S_BYTE,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                is_write;
    logic [ADDR_W-1:0]   address;
    logic [LEN_W-1:0]    length;
    logic [TAG_W-1:0]    tag;
    logic [SRC_W-1:0]    source;
    logic [DATA_W-1:0]   data;
  } entry_t;

  typedef struct packed {
    logic  clear_wr;
    logic  push;
    logic  tick;
    logic  mul_load;
    logic  div_start;
    logic  fin_load;
    logic  red_init;
    logic  red_step;
    logic  byte_step;
    logic  pop;
    logic  res_load;
    logic  res_done;
    kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic size_err;
    logic full;
    logic empty;
    logic active;
    logic reached;
    logic div_done;
    logic red_last;
    logic len_zero;
    logic byte_last;
    logic head_write;
  } status_t;

endpackage

### rtl/core/tfmm_div.sv
module tfmm_div
  import tfmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [LINE_W-1:0] divisor,
  output logic              done,
  output logic [NUM_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(NUM_W);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [LINE_W-1:0] rem;
  logic [LINE_W-1:0] dvs;
  logic [NUM_W-1:0]  num;
  logic [LINE_W:0]   shifted;
  logic              fits;

  assign shifted  = {rem, num[NUM_W-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      num <= dividend;
    end else if (run) begin
      rem <= fits ? LINE_W'(shifted - {1'b0, dvs}) : shifted[LINE_W-1:0];
      num <= {num[NUM_W-2:0], fits};
    end
  end

endmodule

### rtl/core/tfmm_dp.sv
module tfmm_dp
  import tfmm_pkg::*;
#(
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF,
  parameter int MAX_ACCESS_BYTES = MAX_ACCESS_BYTES_DEF,
  parameter int MEMORY_BYTES     = MEMORY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [1:0]        action,
  input  logic [ADDR_W-1:0] address,
  input  logic [LEN_W-1:0]  length,
  input  logic [TAG_W-1:0]  tag,
  input  logic [SRC_W-1:0]  source,
  input  logic [DATA_W-1:0] write_data,
  output logic              strobe,
  output logic [2:0]        kind,
  output logic [TAG_W-1:0]  done_tag,
  output logic [SRC_W-1:0]  done_source,
  output logic [DATA_W-1:0] read_data
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(MEMORY_BYTES);
  localparam int RW = AW + 9;
  localparam logic [RW-1:0] MSH_INIT = RW'(MEMORY_BYTES) << 8;

  logic [LAT_W-1:0]  base_latency;
  logic [LAT_W-1:0]  per_line_latency;
  logic [LINE_W-1:0] line_bytes;

  entry_t queue_mem [QUEUE_DEPTH];
  entry_t head_q;
  logic [QW-1:0] head;
  logic [QW-1:0] tail;
  logic [CW-1:0] count;

  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] finish_time;
  logic [TICK_W-1:0] tick_diff;
  logic              active;

  logic [LINE_W-1:0] line_eff;
  logic [LINE_W-1:0] line_div;
  logic [SPAN_W-1:0] span;
  logic [NUM_W-1:0]  prod;
  logic              div_done;
  logic [NUM_W-1:0]  quot;

  logic [RW-1:0]        red_r;
  logic [RW-1:0]        red_r_next;
  logic [RW-1:0]        msh;
  logic [RED_CNT_W-1:0] red_cnt;

  logic [7:0]        store_mem [MEMORY_BYTES];
  logic [7:0]        store_q;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     ptr;
  logic              store_we;
  logic [AW-1:0]     store_waddr;
  logic [7:0]        store_wdata;
  logic [2:0]        bidx;
  logic [2:0]        cap_idx;
  logic              cap;
  logic [DATA_W-1:0] rd_acc;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_latency     <= LAT_W'(1);
      per_line_latency <= LAT_W'(1);
      line_bytes       <= LINE_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE:     base_latency     <= cfg_data;
        CFG_PER_LINE: per_line_latency <= cfg_data;
        CFG_LINE:     line_bytes       <= cfg_data[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // request queue
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      queue_mem[tail] <= '{is_write: (action == ACT_WRITE), address: address,
                           length: length, tag: tag, source: source,
                           data: write_data};
    end
    head_q <= queue_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.push) begin
        tail  <= (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        head  <= (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
    end
  end

  // tick timing
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      finish_time <= '0;
      active      <= 1'b0;
    end else begin
      if (cmd.tick) begin
        tick_count <= tick_count + 1'b1;
      end
      if (cmd.fin_load) begin
        finish_time <= tick_count + TICK_W'(base_latency) + TICK_W'(quot);
        active      <= 1'b1;
      end else if (cmd.pop) begin
        finish_time <= '0;
        active      <= 1'b0;
      end
    end
  end

  assign tick_diff = tick_count - finish_time;

  // per-line term of the finish time: per_line times (length + line - 1), over line
  assign line_eff = (line_bytes == '0) ? LINE_W'(1) : line_bytes;
  assign span     = SPAN_W'(head_q.length) + SPAN_W'(line_eff) - SPAN_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod     <= NUM_W'(per_line_latency) * NUM_W'(span);
      line_div <= line_eff;
    end
  end

  tfmm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (line_div),
    .done     (div_done),
    .quotient (quot)
  );

  // address modulo memory size
  assign red_r_next = (red_r >= msh) ? red_r - msh : red_r;

  always_ff @(posedge clk) begin
    if (cmd.red_init) begin
      red_r   <= RW'(head_q.address);
      msh     <= MSH_INIT;
      red_cnt <= '0;
    end else if (cmd.red_step) begin
      red_r   <= red_r_next;
      msh     <= msh >> 1;
      red_cnt <= red_cnt + 1'b1;
    end
  end

  // byte store
  assign store_we    = cmd.clear_wr | (cmd.byte_step & head_q.is_write);
  assign store_waddr = cmd.clear_wr ? clr_addr : ptr;
  assign store_wdata = cmd.clear_wr ? 8'd0 : head_q.data[bidx*8 +: 8];

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    store_q <= store_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= 1'b0;
    end else begin
      cap <= cmd.byte_step & ~head_q.is_write;
    end
  end

  always_ff @(posedge clk) begin
    cap_idx <= bidx;
    if (cmd.red_step && red_cnt == RED_CNT_W'(RED_STEPS - 1)) begin
      ptr <= red_r_next[AW-1:0];
    end else if (cmd.byte_step) begin
      ptr <= (ptr == AW'(MEMORY_BYTES - 1)) ? '0 : ptr + 1'b1;
    end
    if (cmd.red_init) begin
      bidx   <= '0;
      rd_acc <= '0;
    end else begin
      if (cmd.byte_step) begin
        bidx <= bidx + 1'b1;
      end
      if (cap) begin
        rd_acc[cap_idx*8 +: 8] <= store_q;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      kind <= cmd.res_kind;
      if (cmd.res_done) begin
        done_tag    <= head_q.tag;
        done_source <= head_q.source;
        read_data   <= head_q.is_write ? '0 : rd_acc;
      end else begin
        done_tag    <= '0;
        done_source <= '0;
        read_data   <= '0;
      end
    end
  end

  always_comb begin
    status.clear_last = clr_addr == AW'(MEMORY_BYTES - 1);
    status.size_err   = length > LEN_W'(MAX_ACCESS_BYTES);
    status.full       = count == CW'(QUEUE_DEPTH);
    status.empty      = count == '0;
    status.active     = active;
    status.reached    = ~tick_diff[TICK_W-1];
    status.div_done   = div_done;
    status.red_last   = red_cnt == RED_CNT_W'(RED_STEPS - 1);
    status.len_zero   = head_q.length == '0;
    status.byte_last  = {1'b0, bidx} == head_q.length - LEN_W'(1);
    status.head_write = head_q.is_write;
  end

endmodule

### rtl/core/tfmm_ctrl.sv
module tfmm_ctrl
  import tfmm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] action,
  input  status_t    status,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_kind = KIND_ACCEPTED;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (action == ACT_READ || action == ACT_WRITE) begin
            cmd.res_load = 1'b1;
            if (status.size_err) begin
              cmd.res_kind = KIND_SIZE_ERR;
            end else if (status.full) begin
              cmd.res_kind = KIND_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (action == ACT_TICK) begin
            cmd.tick = 1'b1;
            if (!status.empty) begin
              state_next = S_HEAD;
            end
          end
        end
      end
      S_HEAD: begin
        if (!status.active) begin
          cmd.mul_load = 1'b1;
          state_next   = S_DIV_START;
        end else if (status.reached) begin
          cmd.red_init = 1'b1;
          state_next   = S_REDUCE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.fin_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_REDUCE: begin
        cmd.red_step = 1'b1;
        if (status.red_last) begin
          state_next = status.len_zero ? S_DONE : S_BYTE;
        end
      end
      S_BYTE: begin
        cmd.byte_step = 1'b1;
        if (status.byte_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.pop      = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_done = 1'b1;
        cmd.res_kind = status.head_write ? KIND_WRITE_DONE : KIND_READ_DONE;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/timed_fifo_memory_model.sv
// In-order memory request queue with a computed per-request latency.
// After reset the byte store is cleared one byte per cycle, and busy stays
// high until it is clear, before the first item is taken. A read or write
// request stays in the idle state and its accepted, queue full or size
// error beat appears on the next cycle; requests can follow every
// cycle. A tick with an empty queue stays idle; one with a timed head not
// yet due goes on to the check of the head and back to idle. A tick that
// starts the head loads the latency product, runs the bit-serial latency
// divider (26 steps) and loads the finish time. A tick that completes the
// head reduces the address modulo the memory size, accesses the byte store
// once per byte and pops the head; a zero length skips the byte accesses.
// Each result beat is shown for exactly one cycle with strobe high; there
// is no way to stall it, so the receiver must take every beat.
module timed_fifo_memory_model
  import tfmm_pkg::*;
#(
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF,
  parameter int MAX_ACCESS_BYTES = MAX_ACCESS_BYTES_DEF,
  parameter int MEMORY_BYTES     = MEMORY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        action,
  input  logic [ADDR_W-1:0] address,
  input  logic [LEN_W-1:0]  length,
  input  logic [TAG_W-1:0]  tag,
  input  logic [SRC_W-1:0]  source,
  input  logic [DATA_W-1:0] write_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              strobe,
  output logic [2:0]        kind,
  output logic [TAG_W-1:0]  done_tag,
  output logic [SRC_W-1:0]  done_source,
  output logic [DATA_W-1:0] read_data
);

  cmd_t    cmd;
  status_t status;

  tfmm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tfmm_dp #(
    .QUEUE_DEPTH      (QUEUE_DEPTH),
    .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES),
    .MEMORY_BYTES     (MEMORY_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .address     (address),
    .length      (length),
    .tag         (tag),
    .source      (source),
    .write_data  (write_data),
    .strobe      (strobe),
    .kind        (kind),
    .done_tag    (done_tag),
    .done_source (done_source),
    .read_data   (read_data)
  );

endmodule

### test/mem_queue_checker.sv
module mem_queue_checker
  import tfmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        action,
  input  logic [ADDR_W-1:0] address,
  input  logic [LEN_W-1:0]  length,
  input  logic [TAG_W-1:0]  tag,
  input  logic [SRC_W-1:0]  source,
  input  logic [DATA_W-1:0] write_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              strobe,
  input  logic [2:0]        kind,
  input  logic [TAG_W-1:0]  done_tag,
  input  logic [SRC_W-1:0]  done_source,
  input  logic [DATA_W-1:0] read_data,
  output int                errors,
  output int                pending,
  output int                queued
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t             kind;
    logic [TAG_W-1:0]  tag;
    logic [SRC_W-1:0]  src;
    logic [DATA_W-1:0] data;
  } beat_t;

  beat_t expected_beats[$];

  entry_t      req_fifo [QUEUE_DEPTH_DEF];
  logic [3:0]  q_head;
  int          q_count;
  logic [31:0] tick_cnt;
  logic [31:0] finish_at;
  bit          timing;
  logic [LAT_W-1:0]  base_lat;
  logic [LAT_W-1:0]  line_lat;
  logic [LINE_W-1:0] line_sz;
  logic [7:0]  store [MEMORY_BYTES_DEF];
  int          err_cnt = 0;

  always @(posedge clk) begin
    beat_t want;
    beat_t pred;
    entry_t ent;
    int slot;
    logic [ADDR_W-1:0] at;
    logic [63:0] line;
    logic [63:0] cost;
    if (rst) begin
      base_lat = 16'd1;
      line_lat = 16'd1;
      line_sz = 9'd8;
      q_head = '0;
      q_count = 0;
      tick_cnt = '0;
      finish_at = '0;
      timing = 1'b0;
      for (int k = 0; k < MEMORY_BYTES_DEF; k++) store[k] = 8'h00;
      expected_beats.delete();
    end else begin
      if (strobe === 1'b1) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: kind %0d, tag %h", kind, done_tag);
          err_cnt++;
        end else begin
          want = expected_beats.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            err_cnt++;
          end
          if (done_tag !== want.tag) begin
            $error("done_tag: expected %h, got %h", want.tag, done_tag);
            err_cnt++;
          end
          if (done_source !== want.src) begin
            $error("done_source: expected %h, got %h", want.src, done_source);
            err_cnt++;
          end
          if (read_data !== want.data) begin
            $error("read_data: expected %h, got %h", want.data, read_data);
            err_cnt++;
          end
        end
      end

      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_BASE:     base_lat = cfg_data;
          CFG_PER_LINE: line_lat = cfg_data;
          CFG_LINE:     line_sz = cfg_data[LINE_W-1:0];
          default: ;
        endcase
      end

      if (start === 1'b1 && busy === 1'b0) begin
        pred = '0;
        if (action == ACT_READ || action == ACT_WRITE) begin
          if (length > MAX_ACCESS_BYTES_DEF) begin
            pred.kind = KIND_SIZE_ERR;
          end else if (q_count >= QUEUE_DEPTH_DEF) begin
            pred.kind = KIND_FULL;
          end else begin
            ent.is_write = (action == ACT_WRITE);
            ent.address = address;
            ent.length = length;
            ent.tag = tag;
            ent.source = source;
            ent.data = write_data;
            slot = (int'(q_head) + q_count) % QUEUE_DEPTH_DEF;
            req_fifo[slot] = ent;
            q_count++;
            pred.kind = KIND_ACCEPTED;
          end
          expected_beats.push_back(pred);
        end else if (action == ACT_TICK) begin
          tick_cnt = tick_cnt + 32'd1;
          if (q_count != 0) begin
            ent = req_fifo[q_head];
            if (!timing) begin
              // zero line size counts as one
              line = (line_sz == 0) ? 64'd1 : 64'(line_sz);
              cost = 64'(line_lat) * (64'(ent.length) + line - 64'd1);
              finish_at = tick_cnt + 32'(64'(base_lat) + cost / line);
              timing = 1'b1;
            end else if (32'(tick_cnt - finish_at) < 32'h8000_0000) begin
              for (int i = 0; i < int'(ent.length); i++) begin
                at = ent.address + ADDR_W'(i);
                if (ent.is_write) store[at] = ent.data[8*i +: 8];
                else pred.data[8*i +: 8] = store[at];
              end
              if (ent.is_write) pred.kind = KIND_WRITE_DONE;
              else pred.kind = KIND_READ_DONE;
              pred.tag = ent.tag;
              pred.src = ent.source;
              q_head = q_head + 4'd1;
              q_count--;
              timing = 1'b0;
              finish_at = '0;
              expected_beats.push_back(pred);
            end
          end
        end
      end
    end
    errors <= err_cnt;
    pending <= expected_beats.size();
    queued <= q_count;
  end

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tfmm_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        action;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  length;
  logic [TAG_W-1:0]  tag;
  logic [SRC_W-1:0]  source;
  logic [DATA_W-1:0] write_data;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              strobe;
  logic [2:0]        kind;
  logic [TAG_W-1:0]  done_tag;
  logic [SRC_W-1:0]  done_source;
  logic [DATA_W-1:0] read_data;

  int errors;
  int pending;
  int queued;
  bit gaps_on = 1'b1;

  timed_fifo_memory_model uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .address(address), .length(length), .tag(tag),
    .source(source), .write_data(write_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .kind(kind), .done_tag(done_tag),
    .done_source(done_source), .read_data(read_data)
  );

  mem_queue_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .address(address), .length(length), .tag(tag),
    .source(source), .write_data(write_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .kind(kind), .done_tag(done_tag),
    .done_source(done_source), .read_data(read_data),
    .errors(errors), .pending(pending), .queued(queued)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return ADDR_W'($urandom_range(0, 63));
    if (r < 6) return 16'hFFF8 + ADDR_W'($urandom_range(0, 7));
    return ADDR_W'($urandom());
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    if ($urandom_range(0, 99) < 85) return LEN_W'($urandom_range(0, 8));
    return LEN_W'($urandom_range(9, 15));
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // returns at the edge that takes the beat
  task automatic send_item(input logic [1:0] act, input logic [ADDR_W-1:0] a,
                           input logic [LEN_W-1:0] n, input logic [TAG_W-1:0] tg,
                           input logic [SRC_W-1:0] src, input logic [DATA_W-1:0] wd);
    start <= 1'b1;
    action <= act;
    address <= a;
    length <= n;
    tag <= tg;
    source <= src;
    write_data <= wd;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic send_random(input logic [1:0] act);
    send_item(act, rand_addr(), rand_len(), TAG_W'($urandom()), SRC_W'($urandom()),
              {$urandom(), $urandom()});
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy !== 1'b0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_latency(input logic [LAT_W-1:0] b, input logic [LAT_W-1:0] p,
                              input logic [LINE_W-1:0] l);
    quiesce();
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_data <= b;
    @(posedge clk);
    cfg_index <= CFG_PER_LINE;
    cfg_data <= p;
    @(posedge clk);
    cfg_index <= CFG_LINE;
    cfg_data <= CFG_W'(l);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // tick until every queued request has completed
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (queued != 0) send_random(ACT_TICK);
  endtask

  task automatic random_phase(input int n_items);
    int count;
    int r;
    int g;
    count = 0;
    while (count < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // request burst, can overflow the queue
        repeat (18) send_random($urandom_range(0, 1) ? ACT_WRITE : ACT_READ);
        count += 18;
      end else if (r < 52) begin
        send_random(ACT_TICK);
        count++;
      end else if (r < 75) begin
        send_random(ACT_READ);
        count++;
      end else if (r < 98) begin
        send_random(ACT_WRITE);
        count++;
      end else begin
        send_random(ACT_UNUSED);
      end
      if ($urandom_range(0, 49) == 0) gaps_on = !gaps_on;
      if ($urandom_range(0, 59) == 0) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end else if (gaps_on) begin
        g = rand_gap();
        if (g > 0) begin
          start <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    int n;
    rst = 1'b1;
    start = 1'b0;
    action = ACT_TICK;
    address = '0;
    length = '0;
    tag = '0;
    source = '0;
    write_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_BASE;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset latency settings
    send_item(ACT_TICK, 16'h0000, 4'd0, 16'h0000, 4'h0, 64'd0);
    send_item(ACT_WRITE, 16'hFFFC, 4'd8, 16'hFFFF, 4'hF, 64'hFEDC_BA98_7654_3210);
    send_item(ACT_READ, 16'hFFFC, 4'd8, 16'h0000, 4'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_WRITE, 16'hFFFF, 4'd0, 16'h5A5A, 4'h5, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_READ, 16'hFFFE, 4'd3, 16'h8001, 4'h8, 64'd0);
    send_item(ACT_READ, 16'hFFFF, 4'd2, 16'h7FFE, 4'h7, 64'd0);
    send_item(ACT_READ, 16'h0100, 4'd0, 16'h0101, 4'h1, 64'd0);
    send_item(ACT_READ, 16'h0040, 4'd9, 16'h0202, 4'h2, 64'd0);
    send_item(ACT_WRITE, 16'hFFFF, 4'd15, 16'h0303, 4'h3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_UNUSED, 16'hFFFF, 4'd15, 16'hFFFF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    send_item(ACT_WRITE, 16'h0010, 4'd5, 16'h0001, 4'h1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_READ, 16'h000E, 4'd8, 16'h0002, 4'h2, 64'd0);
    drain();

    // long latencies: large base with zero line size, then a per-line
    // product past 16 bits
    load_latency(16'd60, 16'hFFFF, 9'd0);
    send_item(ACT_READ, 16'h1234, 4'd0, 16'h1111, 4'h1, 64'd0);
    drain();
    load_latency(16'h0000, 16'd130, 9'd511);
    send_item(ACT_WRITE, 16'h1234, 4'd1, 16'hABCD, 4'hC, 64'h0000_0000_0000_00A5);
    drain();

    // zero latency still waits one tick
    load_latency(16'h0000, 16'h0000, 9'd1);
    send_item(ACT_READ, 16'h1233, 4'd3, 16'h2222, 4'h2, 64'd0);
    random_phase(100);
    drain();
    load_latency(16'd2, 16'd3, 9'd0);
    random_phase(100);
    drain();
    load_latency(16'd1, 16'd4, 9'd256);
    random_phase(100);
    drain();
    load_latency(16'd3, 16'd1, 9'd511);
    random_phase(100);
    drain();
    load_latency(LAT_W'($urandom_range(0, 5)), LAT_W'($urandom_range(0, 5)),
                 LINE_W'($urandom_range(2, 64)));
    random_phase(100);
    drain();

    start <= 1'b0;
    @(posedge clk);
    n = 0;
    while ((pending != 0 || busy !== 1'b0) && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
